// ===== rtl/fse_pkg.sv =====
// Shared package for the floor-sum engine: operand widths, datapath
// commands, controller states and the status bundle.
// No dependencies.
package fse_pkg;

    // Width of every input operand.
    localparam int OB       = 31;
    // Term count width: holds last_index + 1.
    localparam int CNT_W    = OB + 1;
    // Shared multiplier operand width and its product width.
    localparam int MUL_W    = CNT_W;
    localparam int PROD_W   = 2 * MUL_W;
    // Accumulator width, fixed by the result field.
    localparam int ACC_W    = 64;
    // Serial divider dividend width: a * last + b stays below 2^(2*OB+1).
    localparam int DIVN_W   = 2 * OB + 1;
    localparam int DIV_CNT_W = $clog2(DIVN_W + 1);
    // Stream widths, rounded up to whole bytes.
    localparam int S_TDATA_W = ((4 * OB + 7) / 8) * 8;
    localparam int M_TDATA_W = ACC_W;

    // Commands from the controller to the datapath.
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DIV_A,
        CMD_DIV_B,
        CMD_DIV_M,
        CMD_SAVE_QA,
        CMD_SAVE_QB,
        CMD_SAVE_M,
        CMD_MUL_TRI,
        CMD_SAVE_TRI,
        CMD_MUL_TLO,
        CMD_MUL_THI,
        CMD_MUL_CQB,
        CMD_MUL_AL,
        CMD_MUL_ML,
        CMD_ACC_LO,
        CMD_ACC_HI,
        CMD_REFLECT,
        CMD_EMIT
    } dp_cmd_t;

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_R_DIVA,
        ST_R_WA,
        ST_R_SQA,
        ST_R_DIVB,
        ST_R_WB,
        ST_R_SQB,
        ST_R_MTRI,
        ST_R_STRI,
        ST_R_MTLO,
        ST_R_ALO,
        ST_R_MTHI,
        ST_R_AHI,
        ST_R_MCQB,
        ST_R_ACQB,
        ST_X_MAL,
        ST_X_DIVM,
        ST_X_WM,
        ST_X_SM,
        ST_X_MML,
        ST_X_AML,
        ST_X_REFL,
        ST_F_DIVB,
        ST_F_WB,
        ST_F_SQB,
        ST_F_MCQB,
        ST_F_ACQB,
        ST_EMIT
    } fse_state_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic c_zero;
        logic a_zero;
        logic cnt_zero;
        logic reduce;
        logic div_busy;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/fse_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on fse_pkg.
module fse_div import fse_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              short_op,
    input  logic [DIVN_W-1:0] dividend,
    input  logic [OB-1:0]     divisor,
    output logic              busy,
    output logic [DIVN_W-1:0] quotient,
    output logic [OB-1:0]     remainder
);

    logic [DIVN_W-1:0]    quo_reg, quo_next;
    logic [OB-1:0]        rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic [OB:0]          trial;
    logic [OB:0]          diff;
    logic                 fits;

    // One trial subtraction of the shifted partial remainder.
    always_comb begin
        trial = {rem_reg, quo_reg[DIVN_W-1]};
        diff  = trial - {1'b0, divisor};
        fits  = (trial >= {1'b0, divisor});
    end

    // Next values: a short operation pre-aligns an OB-bit dividend to the top.
    always_comb begin
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        if (start) begin
            quo_next   = short_op ? (dividend << (DIVN_W - OB)) : dividend;
            rem_next   = '0;
            count_next = short_op ? DIV_CNT_W'(OB) : DIV_CNT_W'(DIVN_W);
        end else if (count_reg != '0) begin
            quo_next   = {quo_reg[DIVN_W-2:0], fits};
            rem_next   = fits ? diff[OB-1:0] : trial[OB-1:0];
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy      = (count_reg != '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/fse_dp.sv =====
// Datapath of the floor-sum engine: operand registers, shared multiplier,
// serial divider, signed accumulator and the result word register.
// Depends on fse_pkg and fse_div.
module fse_dp import fse_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    input  logic [OB-1:0]        in_slope,
    input  logic [OB-1:0]        in_offset,
    input  logic [OB-1:0]        in_divisor,
    input  logic [OB-1:0]        in_last_index,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata,
    output dp_status_t           status
);

    logic [OB-1:0]     a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, m_reg, m_next;
    logic [OB-1:0]     qa_reg, qa_next, qb_reg, qb_next;
    logic [PROD_W-1:0] mul_reg, mul_next, tri_reg, tri_next;
    logic [ACC_W-1:0]  acc_reg, acc_next, term;
    logic              neg_reg, neg_next;
    logic [ACC_W-1:0]  out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic [OB-1:0]     last;
    logic [MUL_W-1:0]  mul_x, mul_y;
    logic              div_start, div_short, div_busy;
    logic [DIVN_W-1:0] div_dividend, div_quo;
    logic [OB-1:0]     div_rem;

    assign last = OB'(cnt_reg - 1'b1);

    // Divider hookup.
    always_comb begin
        div_start    = 1'b0;
        div_short    = 1'b1;
        div_dividend = DIVN_W'(a_reg);
        case (cmd)
            CMD_DIV_A: begin
                div_start = 1'b1;
            end
            CMD_DIV_B: begin
                div_start    = 1'b1;
                div_dividend = DIVN_W'(b_reg);
            end
            CMD_DIV_M: begin
                div_start    = 1'b1;
                div_short    = 1'b0;
                div_dividend = DIVN_W'(mul_reg + PROD_W'(b_reg));
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    fse_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .short_op  (div_short),
        .dividend  (div_dividend),
        .divisor   (c_reg),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_x = MUL_W'(last);
        mul_y = cnt_reg;
        case (cmd)
            CMD_MUL_TLO: begin
                mul_x = tri_reg[MUL_W-1:0];
                mul_y = MUL_W'(qa_reg);
            end
            CMD_MUL_THI: begin
                mul_x = tri_reg[PROD_W-1:MUL_W];
                mul_y = MUL_W'(qa_reg);
            end
            CMD_MUL_CQB: begin
                mul_x = cnt_reg;
                mul_y = MUL_W'(qb_reg);
            end
            CMD_MUL_AL: begin
                mul_x = MUL_W'(a_reg);
                mul_y = MUL_W'(last);
            end
            CMD_MUL_ML: begin
                mul_x = m_reg;
                mul_y = MUL_W'(last);
            end
            default: begin
                mul_x = MUL_W'(last);
                mul_y = cnt_reg;
            end
        endcase
    end

    // Accumulator term: the low form takes the product, the high form takes it
    // shifted up by one multiplier operand width; it is added, or subtracted while the sign flag is set, modulo 2^64.
    always_comb begin
        term = ACC_W'(mul_reg);
        if (cmd == CMD_ACC_HI) begin
            term = term << MUL_W;
        end
    end

    // Register updates per command.
    always_comb begin
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        cnt_next       = cnt_reg;
        m_next         = m_reg;
        qa_next        = qa_reg;
        qb_next        = qb_reg;
        tri_next       = tri_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        mul_next       = mul_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (cmd)
            CMD_LOAD: begin
                a_next   = in_slope;
                b_next   = in_offset;
                c_next   = in_divisor;
                cnt_next = CNT_W'(in_last_index) + 1'b1;
                acc_next = '0;
                neg_next = 1'b0;
            end
            CMD_SAVE_QA: begin
                qa_next = div_quo[OB-1:0];
                a_next  = div_rem;
            end
            CMD_SAVE_QB: begin
                qb_next = div_quo[OB-1:0];
                b_next  = div_rem;
            end
            CMD_SAVE_M: begin
                m_next = div_quo[CNT_W-1:0];
            end
            CMD_SAVE_TRI: begin
                tri_next = mul_reg >> 1;
            end
            CMD_MUL_TRI, CMD_MUL_TLO, CMD_MUL_THI, CMD_MUL_CQB,
            CMD_MUL_AL, CMD_MUL_ML: begin
                mul_next = PROD_W'(mul_x) * PROD_W'(mul_y);
            end
            CMD_ACC_LO, CMD_ACC_HI: begin
                acc_next = neg_reg ? (acc_reg - term) : (acc_reg + term);
            end
            CMD_REFLECT: begin
                b_next   = c_reg - b_reg - 1'b1;
                a_next   = c_reg;
                c_next   = a_reg;
                cnt_next = m_reg;
                neg_next = !neg_reg;
            end
            CMD_EMIT: begin
                out_next       = acc_reg;
                out_valid_next = 1'b1;
            end
            default: begin
                out_next = out_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        cnt_reg <= cnt_next;
        m_reg   <= m_next;
        qa_reg  <= qa_next;
        qb_reg  <= qb_next;
        tri_reg <= tri_next;
        acc_reg <= acc_next;
        neg_reg <= neg_next;
        mul_reg <= mul_next;
        out_reg <= out_next;
    end

    // Status back to the controller.
    always_comb begin
        status.c_zero   = (c_reg == '0);
        status.a_zero   = (a_reg == '0);
        status.cnt_zero = (cnt_reg == '0);
        status.reduce   = (a_reg >= c_reg) || (b_reg >= c_reg);
        status.div_busy = div_busy;
        status.out_free = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

// ===== rtl/fse_ctrl.sv =====
// Controller of the floor-sum engine: sequences reduction, reflection and
// the final step by issuing one datapath command per cycle.
// Depends on fse_pkg.
module fse_ctrl import fse_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    fse_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_CHECK;
            ST_CHECK: begin
                if (status.c_zero) begin
                    state_next = ST_EMIT;
                end else if (status.a_zero || status.cnt_zero) begin
                    state_next = ST_F_DIVB;
                end else if (status.reduce) begin
                    state_next = ST_R_DIVA;
                end else begin
                    state_next = ST_X_MAL;
                end
            end
            ST_R_DIVA: state_next = ST_R_WA;
            ST_R_WA:   if (!status.div_busy) state_next = ST_R_SQA;
            ST_R_SQA:  state_next = ST_R_DIVB;
            ST_R_DIVB: state_next = ST_R_WB;
            ST_R_WB:   if (!status.div_busy) state_next = ST_R_SQB;
            ST_R_SQB:  state_next = ST_R_MTRI;
            ST_R_MTRI: state_next = ST_R_STRI;
            ST_R_STRI: state_next = ST_R_MTLO;
            ST_R_MTLO: state_next = ST_R_ALO;
            ST_R_ALO:  state_next = ST_R_MTHI;
            ST_R_MTHI: state_next = ST_R_AHI;
            ST_R_AHI:  state_next = ST_R_MCQB;
            ST_R_MCQB: state_next = ST_R_ACQB;
            ST_R_ACQB: state_next = ST_CHECK;
            ST_X_MAL:  state_next = ST_X_DIVM;
            ST_X_DIVM: state_next = ST_X_WM;
            ST_X_WM:   if (!status.div_busy) state_next = ST_X_SM;
            ST_X_SM:   state_next = ST_X_MML;
            ST_X_MML:  state_next = ST_X_AML;
            ST_X_AML:  state_next = ST_X_REFL;
            ST_X_REFL: state_next = ST_CHECK;
            ST_F_DIVB: state_next = ST_F_WB;
            ST_F_WB:   if (!status.div_busy) state_next = ST_F_SQB;
            ST_F_SQB:  state_next = ST_F_MCQB;
            ST_F_MCQB: state_next = ST_F_ACQB;
            ST_F_ACQB: state_next = ST_EMIT;
            ST_EMIT:   if (status.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd      = CMD_NONE;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd = CMD_LOAD;
            end
            ST_R_DIVA: cmd = CMD_DIV_A;
            ST_R_SQA:  cmd = CMD_SAVE_QA;
            ST_R_DIVB: cmd = CMD_DIV_B;
            ST_R_SQB:  cmd = CMD_SAVE_QB;
            ST_R_MTRI: cmd = CMD_MUL_TRI;
            ST_R_STRI: cmd = CMD_SAVE_TRI;
            ST_R_MTLO: cmd = CMD_MUL_TLO;
            ST_R_ALO:  cmd = CMD_ACC_LO;
            ST_R_MTHI: cmd = CMD_MUL_THI;
            ST_R_AHI:  cmd = CMD_ACC_HI;
            ST_R_MCQB: cmd = CMD_MUL_CQB;
            ST_R_ACQB: cmd = CMD_ACC_LO;
            ST_X_MAL:  cmd = CMD_MUL_AL;
            ST_X_DIVM: cmd = CMD_DIV_M;
            ST_X_SM:   cmd = CMD_SAVE_M;
            ST_X_MML:  cmd = CMD_MUL_ML;
            ST_X_AML:  cmd = CMD_ACC_LO;
            ST_X_REFL: cmd = CMD_REFLECT;
            ST_F_DIVB: cmd = CMD_DIV_B;
            ST_F_SQB:  cmd = CMD_SAVE_QB;
            ST_F_MCQB: cmd = CMD_MUL_CQB;
            ST_F_ACQB: cmd = CMD_ACC_LO;
            ST_EMIT:   if (status.out_free) cmd = CMD_EMIT;
            default:   cmd = CMD_NONE;
        endcase
    end

endmodule

// ===== rtl/floor_sum_engine.sv =====
// Floor-sum engine: for one request word (a, b, c, n) it returns one word
// holding the sum of floor((a*i + b) / c) for i = 0..n, modulo 2^64.
//
// The slave channel takes request words while s_tready is high, which is
// only when no request is in progress. The master channel offers the result
// word in an output register; the next request may be taken while that
// word still waits for m_tready, and a stalled receiver only holds the
// engine once a second result is ready to be written.
// A zero divisor gives a result of zero.
//
// The work runs as Euclid-like rounds in a serial divider of one bit a
// cycle and a shared 32 x 32 multiplier: reducing rounds, reflecting
// rounds and the closing step, which writes the result word; the engine
// then returns to idle, where the next request is taken. In the worst
// case the serial divider sets the time a request takes.
// Reset clears the controller and the output valid flag; no result is
// offered after reset until a request has been processed.
//
// Depends on fse_pkg, fse_ctrl, fse_dp.
module floor_sum_engine import fse_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Fields from bit 0 up: slope, offset, divisor, last_index, zero padding.
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Fields from bit 0 up: total.
    output logic [M_TDATA_W-1:0] m_tdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    fse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fse_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .in_slope      (s_tdata[OB-1:0]),
        .in_offset     (s_tdata[2*OB-1:OB]),
        .in_divisor    (s_tdata[3*OB-1:2*OB]),
        .in_last_index (s_tdata[4*OB-1:3*OB]),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_tdata       (m_tdata),
        .status        (status)
    );

endmodule

// ===== rtl/fse_checker.sv =====
// Port-level checker for the floor-sum engine, bound to the top level.
// Depends on fse_pkg and floor_sum_engine.
module fse_port_checks import fse_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A result word that is not taken stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its value.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word changed while stalled");

    // One request at a time: the slave side closes after a word is taken.
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    // Where none was on offer, no result may appear in the cycle after an accepted request.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result offered before the request was worked");

    // Reset leaves no result on offer.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind floor_sum_engine fse_port_checks u_fse_port_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
